/* sv/cfq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants of the circular FIFO queue: item layouts,
// request and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int ELEM_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int CAP_LOG2_W = 4;

  localparam logic [CAP_LOG2_W-1:0] DEFAULT_CAPACITY_LOG2 = 4'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_DEQUEUE = 2'd1,
    FUNC_PEEK    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NULL_ELEM = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY_LOG2    = 1'b0,
    CFG_RESERVE_ONE_SLOT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]   element_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic fill;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/circular_fifo_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of element handles with enqueue, dequeue, peek and clear
// requests, a power-of-two capacity and an optional reserved slot.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Direction
//  in        in_valid_i / in_ready_o / in_item_i    request items in
//  out       out_valid_o / out_ready_i / out_item_o result items out
//  cfg       cfg_we_i / cfg_idx_i / cfg_data_i      register writes in
//
// Enqueue, clear and failed requests give their result directly; a dequeue or
// peek that hits first waits for the registered read port of the ring storage.
// Storage contents are undefined after reset and need no clearing pass.
// A new item is taken while a result waits, as long as that result leaves
// in the same cycle; a stalled output holds the input back.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
  parameter int DEPTH        = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire cfq_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output cfq_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [cfq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cfq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cfq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  cfq_datapath #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

/* sv/cfq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/cfq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_ctrl
// Controller of the circular FIFO queue: accepts items, waits in a read
// state for storage reads and owns the result valid flag.
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                out_ready_i,
  input  wire cfq_pkg::dp_status_t status_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output cfq_pkg::ctl_cmd_t        cmd_o
);
  import cfq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o.exec  = 1'b0;
    cmd_o.fill  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (out_valid_q && out_ready_i) begin
          out_valid_d = 1'b0;
        end
        if (in_valid_i && in_ready_o) begin
          cmd_o.exec = 1'b1;
          if (status_i.needs_read) begin
            state_d     = S_READ;
            out_valid_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd_o.fill  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* sv/cfq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_datapath
// Datapath of the circular FIFO queue: configuration registers, head and
// tail indexes, entry count, ring storage and the result register.
// ----------------------------------------------------------------------------
module cfq_datapath #(
  parameter int DEPTH        = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cfq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [cfq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire cfq_pkg::in_item_t                   in_item_i,
  input  wire cfq_pkg::ctl_cmd_t                   cmd_i,
  output cfq_pkg::dp_status_t                      status_o,
  output cfq_pkg::out_item_t                       out_item_o
);
  import cfq_pkg::*;

  localparam int IdxW     = $clog2(DEPTH);
  localparam int CntW     = $clog2(DEPTH + 1);
  localparam int MaxLog   = $clog2(DEPTH + 1) - 1;
  localparam int ElemKeep = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
  localparam logic [ELEM_W-1:0]     ElemMask = {ELEM_W{1'b1}} >> (ELEM_W - ElemKeep);
  localparam logic [CAP_LOG2_W:0]   MaxLogV  = (CAP_LOG2_W + 1)'(MaxLog);

  logic [CAP_LOG2_W-1:0] cap_log2_q, cap_log2_d;
  logic                  reserve_q, reserve_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;

  logic [CAP_LOG2_W:0]   eff_log;
  logic [CntW-1:0]       cap;
  logic [CntW-1:0]       limit;
  logic [IdxW-1:0]       idx_mask;
  logic [ELEM_W-1:0]     elem;
  logic [STATUS_W-1:0]   status_d;
  logic                  wr_en;
  logic                  rd_en;
  logic [ELEMENT_BITS-1:0] rdata;

  logic [ELEM_W-1:0]     res_elem_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [COUNT_W-1:0]    res_count_q;
  logic                  res_empty_q;
  logic                  res_full_q;

  assign eff_log  = ({1'b0, cap_log2_q} > MaxLogV) ? MaxLogV : {1'b0, cap_log2_q};
  assign cap      = CntW'(1) << eff_log;
  assign limit    = reserve_q ? CntW'(cap - 1'b1) : cap;
  assign idx_mask = IdxW'(cap - 1'b1);
  assign elem     = in_item_i.element & ElemMask;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = ST_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    status_o.needs_read = 1'b0;
    case (in_item_i.func)
      FUNC_ENQUEUE: begin
        if (elem == '0) begin
          status_d = ST_NULL_ELEM;
        end else if (count_q >= limit) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = cmd_i.exec;
          tail_d  = IdxW'(tail_q + 1'b1) & idx_mask;
          count_d = CntW'(count_q + 1'b1);
        end
      end
      FUNC_DEQUEUE, FUNC_PEEK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          status_o.needs_read = 1'b1;
          rd_en = cmd_i.exec;
          if (in_item_i.func == FUNC_DEQUEUE) begin
            head_d  = IdxW'(head_q + 1'b1) & idx_mask;
            count_d = CntW'(count_q - 1'b1);
          end
        end
      end
      default: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
    endcase
  end

  always_comb begin
    cap_log2_d = cap_log2_q;
    reserve_d  = reserve_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY_LOG2:    cap_log2_d = cfg_data_i[CAP_LOG2_W-1:0];
        CFG_RESERVE_ONE_SLOT: reserve_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= DEFAULT_CAPACITY_LOG2;
      reserve_q  <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else begin
      cap_log2_q <= cap_log2_d;
      reserve_q  <= reserve_d;
      if (cfg_we_i && (cfg_idx_i == CFG_CAPACITY_LOG2)) begin
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.exec) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  cfq_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (ELEMENT_BITS'(elem)),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_elem_q   <= '0;
      res_status_q <= status_d;
      res_count_q  <= COUNT_W'(count_d);
      res_empty_q  <= (count_d == '0);
      res_full_q   <= (count_d >= limit);
    end else if (cmd_i.fill) begin
      res_elem_q   <= ELEM_W'(rdata);
    end
  end

  assign out_item_o.element_out = res_elem_q;
  assign out_item_o.status      = res_status_q;
  assign out_item_o.count       = res_count_q;
  assign out_item_o.is_empty    = res_empty_q;
  assign out_item_o.is_full     = res_full_q;

endmodule
`default_nettype wire

/* sv/cfq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_port_checks
// Port-level checks of the circular FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module cfq_port_checks (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire cfq_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire cfq_pkg::out_item_t out_item_o
);
  import cfq_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.is_empty == (out_item_o.count == '0)))
    else $error("Empty flag disagrees with the count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_EMPTY)
      |-> (out_item_o.element_out == '0) && out_item_o.is_empty)
    else $error("Empty result carries an element or a nonzero count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_FULL) |-> out_item_o.is_full)
    else $error("Full rejection without the full flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.func == FUNC_ENQUEUE) |=> out_valid_o)
    else $error("Enqueue result did not appear in the next cycle.");

endmodule

bind circular_fifo_queue cfq_port_checks u_cfq_port_checks (.*);
`default_nettype wire
